// ----- hw/rtl/fmkc_pkg.sv -----
`timescale 1ns / 1ps

package fmkc_pkg;

	// Key codes as seen on key_direction
	typedef enum logic [2:0] {
		DIR_NONE  = 3'd0,
		DIR_UP    = 3'd1,
		DIR_DN    = 3'd2,
		DIR_WEST  = 3'd3,
		DIR_EAST  = 3'd4
	} key_t;

	// Register map: 32-bit words, index = paddr / 4
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned IDX_W  = ADDR_W - 2;

	localparam logic [IDX_W-1:0] REG_STEP_MARGIN      = 3'd0;
	localparam logic [IDX_W-1:0] REG_TILT_RATIO       = 3'd1;
	localparam logic [IDX_W-1:0] REG_SHUTTER_MIN      = 3'd2;
	localparam logic [IDX_W-1:0] REG_PIXEL_SPREAD_MAX = 3'd3;
	localparam logic [IDX_W-1:0] REG_QUALITY_MIN      = 3'd4;
	localparam logic [IDX_W-1:0] REG_DIST_RESET_LIMIT = 3'd5;
	localparam logic [IDX_W-1:0] REG_KEY_DIST_LIMIT   = 3'd6;

	// Reset values of the registers
	localparam logic [7:0]  RST_STEP_MARGIN      = 8'd2;
	localparam logic [7:0]  RST_TILT_RATIO       = 8'd13;
	localparam logic [15:0] RST_SHUTTER_MIN      = 16'd90;
	localparam logic [7:0]  RST_PIXEL_SPREAD_MAX = 8'd226;
	localparam logic [7:0]  RST_QUALITY_MIN      = 8'd12;
	localparam logic [15:0] RST_DIST_RESET_LIMIT = 16'd1000;
	localparam logic [15:0] RST_KEY_DIST_LIMIT   = 16'd3;

	// Raw delta Y code that the sensor reports for "no motion"
	localparam logic [7:0]  DY_NULL_CODE = 8'h80;
	localparam logic [15:0] TILT_SCALE   = 16'd10;
	localparam logic [15:0] CNT_MAX      = 16'hFFFF;

	typedef struct packed {
		logic [7:0]  step_margin;
		logic [7:0]  tilt_ratio;
		logic [15:0] shutter_min;
		logic [7:0]  pixel_spread_max;
		logic [7:0]  quality_min;
		logic [15:0] disturbance_reset_limit;
		logic [15:0] key_disturbance_limit;
	} cfg_t;

	typedef struct packed {
		logic        overflow_flag;
		logic        motion_flag;
		logic        motion_pin;
		logic [7:0]  delta_x_raw;
		logic [7:0]  delta_y_raw;
		logic [7:0]  surface_quality;
		logic [15:0] shutter_value;
		logic [7:0]  pixel_max;
		logic [7:0]  pixel_min;
	} item_t;

	typedef struct packed {
		key_t key_direction;
		logic clear_motion;
		logic reenable_interrupt;
		logic quality_reject;
	} result_t;

endpackage

// ----- hw/rtl/fmkc_regs.sv -----
`timescale 1ns / 1ps

module fmkc_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [fmkc_pkg::ADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	output fmkc_pkg::cfg_t                cfg
);
	import fmkc_pkg::*;

	cfg_t             cfg_q;
	logic             wr_en;
	logic [IDX_W-1:0] idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = paddr[ADDR_W-1:2];
	assign cfg    = cfg_q;

	// Register writes on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_margin             <= RST_STEP_MARGIN;
			cfg_q.tilt_ratio              <= RST_TILT_RATIO;
			cfg_q.shutter_min             <= RST_SHUTTER_MIN;
			cfg_q.pixel_spread_max        <= RST_PIXEL_SPREAD_MAX;
			cfg_q.quality_min             <= RST_QUALITY_MIN;
			cfg_q.disturbance_reset_limit <= RST_DIST_RESET_LIMIT;
			cfg_q.key_disturbance_limit   <= RST_KEY_DIST_LIMIT;
		end else if (wr_en) begin
			unique case (idx)
				REG_STEP_MARGIN:      cfg_q.step_margin             <= pwdata[7:0];
				REG_TILT_RATIO:       cfg_q.tilt_ratio              <= pwdata[7:0];
				REG_SHUTTER_MIN:      cfg_q.shutter_min             <= pwdata[15:0];
				REG_PIXEL_SPREAD_MAX: cfg_q.pixel_spread_max        <= pwdata[7:0];
				REG_QUALITY_MIN:      cfg_q.quality_min             <= pwdata[7:0];
				REG_DIST_RESET_LIMIT: cfg_q.disturbance_reset_limit <= pwdata[15:0];
				REG_KEY_DIST_LIMIT:   cfg_q.key_disturbance_limit   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Read mux; unmapped words read as zero
	always_comb begin
		unique case (idx)
			REG_STEP_MARGIN:      prdata = {24'd0, cfg_q.step_margin};
			REG_TILT_RATIO:       prdata = {24'd0, cfg_q.tilt_ratio};
			REG_SHUTTER_MIN:      prdata = {16'd0, cfg_q.shutter_min};
			REG_PIXEL_SPREAD_MAX: prdata = {24'd0, cfg_q.pixel_spread_max};
			REG_QUALITY_MIN:      prdata = {24'd0, cfg_q.quality_min};
			REG_DIST_RESET_LIMIT: prdata = {16'd0, cfg_q.disturbance_reset_limit};
			REG_KEY_DIST_LIMIT:   prdata = {16'd0, cfg_q.key_disturbance_limit};
			default:              prdata = 32'd0;
		endcase
	end

endmodule

// ----- hw/rtl/fmkc_classify.sv -----
`timescale 1ns / 1ps

module fmkc_classify (
	input  fmkc_pkg::item_t   item,
	input  fmkc_pkg::cfg_t    cfg,
	input  logic [15:0]       cnt,
	output fmkc_pkg::result_t res,
	output logic [15:0]       cnt_nxt
);
	import fmkc_pkg::*;

	logic [7:0]        spread;
	logic              poor;
	logic [7:0]        dy_raw;
	logic              dx_nz;
	logic              dy_nz;
	logic [7:0]        ax;
	logic [7:0]        ay;
	logic [7:0]        ms;
	logic signed [9:0] x_diff;
	logic signed [9:0] y_diff;
	logic signed [9:0] ms_s;
	logic [15:0]       ax_10;
	logic [15:0]       ay_10;
	logic [15:0]       ax_tr;
	logic [15:0]       ay_tr;
	logic              x_dom;
	logic              y_dom;
	key_t              dir;
	logic [15:0]       cnt_inc;
	logic [15:0]       cnt_dec;

	// Image quality check
	assign spread = (item.pixel_max >= item.pixel_min) ? item.pixel_max - item.pixel_min
	                                                   : item.pixel_min - item.pixel_max;
	assign poor   = (item.shutter_value < cfg.shutter_min) ||
	                (spread > cfg.pixel_spread_max) ||
	                (item.surface_quality <= cfg.quality_min);

	// Delta magnitudes; 0x80 on Y means no motion
	assign dy_raw = (item.delta_y_raw == DY_NULL_CODE) ? 8'd0 : item.delta_y_raw;
	assign dx_nz  = (item.delta_x_raw != 8'd0);
	assign dy_nz  = (dy_raw != 8'd0);
	assign ax     = item.delta_x_raw[7] ? (~item.delta_x_raw + 8'd1) : item.delta_x_raw;
	assign ay     = dy_raw[7] ? (~dy_raw + 8'd1) : dy_raw;
	assign ms     = cfg.step_margin;

	// Dominant axis: margin and tilt (tenths) tests
	assign x_diff = $signed({2'b00, ax}) - $signed({2'b00, ay});
	assign y_diff = $signed({2'b00, ay}) - $signed({2'b00, ax});
	assign ms_s   = $signed({2'b00, ms});
	assign ax_10  = {8'd0, ax} * TILT_SCALE;
	assign ay_10  = {8'd0, ay} * TILT_SCALE;
	assign ax_tr  = {8'd0, ax} * {8'd0, cfg.tilt_ratio};
	assign ay_tr  = {8'd0, ay} * {8'd0, cfg.tilt_ratio};
	assign x_dom  = (x_diff > ms_s) && (ax_10 > ay_tr);
	assign y_dom  = (y_diff > ms_s) && (ay_10 > ax_tr);

	always_comb begin
		if (x_dom) begin
			dir = item.delta_x_raw[7] ? DIR_EAST : DIR_WEST;
		end else if (y_dom) begin
			dir = dy_raw[7] ? DIR_UP : DIR_DN;
		end else begin
			dir = DIR_NONE;
		end
	end

	// Saturating counter steps
	assign cnt_inc = (cnt != CNT_MAX) ? cnt + 16'd1 : cnt;
	assign cnt_dec = (cnt != 16'd0) ? cnt - 16'd1 : cnt;

	// Poll decision and counter update
	always_comb begin
		res.key_direction      = DIR_NONE;
		res.clear_motion       = 1'b0;
		res.reenable_interrupt = 1'b0;
		res.quality_reject     = 1'b0;
		cnt_nxt                = cnt;
		if (item.overflow_flag) begin
			res.clear_motion = 1'b1;
		end else if (item.motion_flag) begin
			if (!item.motion_pin) begin
				res.reenable_interrupt = 1'b1;
			end else begin
				res.clear_motion = 1'b1;
				if (poor) begin
					res.quality_reject = 1'b1;
					cnt_nxt = (cnt_inc > cfg.disturbance_reset_limit) ? 16'd0 : cnt_inc;
				end else begin
					cnt_nxt = cnt_dec;
					if (dx_nz || dy_nz) begin
						if ((!dx_nz && ay <= ms) || (!dy_nz && ax <= ms)) begin
							// small single-axis move: restart
							cnt_nxt = 16'd0;
						end else if (ax > ms || ay > ms) begin
							if (dir != DIR_NONE && cnt_dec < cfg.key_disturbance_limit) begin
								res.key_direction = dir;
							end
							cnt_nxt = 16'd0;
						end
					end
				end
			end
		end
	end

endmodule

// ----- hw/rtl/finger_motion_key_classifier_core.sv -----
`timescale 1ns / 1ps
// Channel  | Handshake                      | Payload
// ---------+--------------------------------+---------------------------------------------
// input    | in_valid / in_ready            | overflow_flag .. pixel_min, one poll a beat
// output   | out_valid / out_ready          | key_direction, clear_motion,
//          |                                | reenable_interrupt, quality_reject
// config   | APB psel/penable/pwrite/pready | paddr (word = 4 bytes), pwdata, prdata
//
// One poll per clock sustained while out_ready stays high. A poll is registered in the
// input stage, where the classifier and the disturbance counter update run, then in
// the result register. The counter is updated as a poll leaves the input stage,
// so the next poll sees it. A stalled output holds the result; the input stage keeps
// one more poll and then in_ready drops. Reset clears the counter, valid flags and
// registers to defaults.

module finger_motion_key_classifier_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [fmkc_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        overflow_flag,
	input  logic                        motion_flag,
	input  logic                        motion_pin,
	input  logic [7:0]                  delta_x_raw,
	input  logic [7:0]                  delta_y_raw,
	input  logic [7:0]                  surface_quality,
	input  logic [15:0]                 shutter_value,
	input  logic [7:0]                  pixel_max,
	input  logic [7:0]                  pixel_min,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [2:0]                  key_direction,
	output logic                        clear_motion,
	output logic                        reenable_interrupt,
	output logic                        quality_reject
);
	import fmkc_pkg::*;

	cfg_t        cfg;
	item_t       item_s1;
	logic        valid_s1;
	result_t     res_c;
	result_t     res_q;
	logic        out_valid_q;
	logic [15:0] cnt_q;
	logic [15:0] cnt_nxt;
	logic        advance;

	fmkc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fmkc_classify u_classify (
		.item    (item_s1),
		.cfg     (cfg),
		.cnt     (cnt_q),
		.res     (res_c),
		.cnt_nxt (cnt_nxt)
	);

	// Flow control
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.overflow_flag   <= overflow_flag;
			item_s1.motion_flag     <= motion_flag;
			item_s1.motion_pin      <= motion_pin;
			item_s1.delta_x_raw     <= delta_x_raw;
			item_s1.delta_y_raw     <= delta_y_raw;
			item_s1.surface_quality <= surface_quality;
			item_s1.shutter_value   <= shutter_value;
			item_s1.pixel_max       <= pixel_max;
			item_s1.pixel_min       <= pixel_min;
		end
	end

	// Disturbance counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= 16'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				cnt_q <= cnt_nxt;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_c;
		end
	end

	assign out_valid          = out_valid_q;
	assign key_direction      = res_q.key_direction;
	assign clear_motion       = res_q.clear_motion;
	assign reenable_interrupt = res_q.reenable_interrupt;
	assign quality_reject     = res_q.quality_reject;

	// Counter moves only when a poll leaves the input stage
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(cnt_q))
		else $error("disturbance count changed without a poll");

	// A sent key always restarts the disturbance count
	a_key_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (res_c.key_direction != DIR_NONE) |=> (cnt_q == 16'd0))
		else $error("key sent but count not cleared");

	// A key or a reject only comes from a poll that also clears motion
	a_key_clr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_q.key_direction != DIR_NONE || res_q.quality_reject)
		|-> res_q.clear_motion && !res_q.reenable_interrupt)
		else $error("key or reject without clear_motion");

	// Key and reject are exclusive
	a_key_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.quality_reject |-> (res_q.key_direction == DIR_NONE))
		else $error("key sent on a rejected poll");

	// Input stage never drops a poll while the result is stalled
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("held poll lost from input stage");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
	import fmkc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// config port
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	// poll channel
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        overflow_flag = 1'b0;
	logic        motion_flag = 1'b0;
	logic        motion_pin = 1'b0;
	logic [7:0]  delta_x_raw = '0;
	logic [7:0]  delta_y_raw = '0;
	logic [7:0]  surface_quality = '0;
	logic [15:0] shutter_value = '0;
	logic [7:0]  pixel_max = '0;
	logic [7:0]  pixel_min = '0;

	// result channel
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  key_direction;
	logic        clear_motion;
	logic        reenable_interrupt;
	logic        quality_reject;

	finger_motion_key_classifier_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.overflow_flag(overflow_flag),
		.motion_flag(motion_flag),
		.motion_pin(motion_pin),
		.delta_x_raw(delta_x_raw),
		.delta_y_raw(delta_y_raw),
		.surface_quality(surface_quality),
		.shutter_value(shutter_value),
		.pixel_max(pixel_max),
		.pixel_min(pixel_min),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.key_direction(key_direction),
		.clear_motion(clear_motion),
		.reenable_interrupt(reenable_interrupt),
		.quality_reject(quality_reject)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow of the register file and the disturbance counter
	cfg_t        reg_shadow;
	logic [15:0] dist_cnt;

	item_t   poll_q[$];
	result_t poll_verdict_q[$];
	int      mismatch_cnt = 0;
	int      beat_cnt = 0;
	bit      idle_on = 1'b0;
	int      wait_left = 0;
	int      stall_left = 0;
	item_t   pend;

	task automatic log_mismatch(input string what, input int got, input int want);
		$display("mismatch at result beat %0d, %s: got %0d want %0d", beat_cnt, what, got, want);
		mismatch_cnt++;
	endtask

	function automatic int draw_idle();
		if (!idle_on || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(0, 9);
	endfunction

	// dominant-axis decision on sign-extended deltas
	function automatic key_t pick_axis(int dx, int dy);
		int ax, ay, ms, tr;
		ax = (dx < 0) ? -dx : dx;
		ay = (dy < 0) ? -dy : dy;
		ms = int'(reg_shadow.step_margin);
		tr = int'(reg_shadow.tilt_ratio);
		if ((ax - ay > ms) && (ax * 10 > ay * tr))
			return (dx > 0) ? DIR_WEST : DIR_EAST;
		if ((ay - ax > ms) && (ay * 10 > ax * tr))
			return (dy > 0) ? DIR_DN : DIR_UP;
		return DIR_NONE;
	endfunction

	// expected outcome of one poll; advances the disturbance counter
	function automatic result_t judge_poll(item_t p);
		result_t r;
		logic [7:0] spread;
		int dx, dy, ax, ay, ms;
		key_t k;
		r.key_direction = DIR_NONE;
		r.clear_motion = 1'b0;
		r.reenable_interrupt = 1'b0;
		r.quality_reject = 1'b0;
		if (p.overflow_flag) begin
			r.clear_motion = 1'b1;
		end else if (p.motion_flag) begin
			if (!p.motion_pin) begin
				r.reenable_interrupt = 1'b1;
			end else begin
				spread = (p.pixel_max >= p.pixel_min) ? p.pixel_max - p.pixel_min
					: p.pixel_min - p.pixel_max;
				r.clear_motion = 1'b1;
				if (p.shutter_value < reg_shadow.shutter_min ||
						spread > reg_shadow.pixel_spread_max ||
						p.surface_quality <= reg_shadow.quality_min) begin
					r.quality_reject = 1'b1;
					if (dist_cnt != 16'hFFFF)
						dist_cnt++;
					if (dist_cnt > reg_shadow.disturbance_reset_limit)
						dist_cnt = '0;
				end else begin
					if (dist_cnt != 0)
						dist_cnt--;
					dx = $signed(p.delta_x_raw);
					dy = (p.delta_y_raw == DY_NULL_CODE) ? 0 : $signed(p.delta_y_raw);
					ax = (dx < 0) ? -dx : dx;
					ay = (dy < 0) ? -dy : dy;
					ms = int'(reg_shadow.step_margin);
					if (dx != 0 || dy != 0) begin
						if ((dx == 0 && ay <= ms) || (dy == 0 && ax <= ms)) begin
							dist_cnt = '0;
						end else if (ax > ms || ay > ms) begin
							k = pick_axis(dx, dy);
							if (k != DIR_NONE && dist_cnt < reg_shadow.key_disturbance_limit)
								r.key_direction = k;
							dist_cnt = '0;
						end
					end
				end
			end
		end
		return r;
	endfunction

	// poll driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid)
				poll_verdict_q.push_back(judge_poll(pend));
			if (wait_left != 0) begin
				wait_left--;
				in_valid <= 1'b0;
			end else if (poll_q.size() != 0) begin
				pend = poll_q.pop_front();
				overflow_flag <= pend.overflow_flag;
				motion_flag <= pend.motion_flag;
				motion_pin <= pend.motion_pin;
				delta_x_raw <= pend.delta_x_raw;
				delta_y_raw <= pend.delta_y_raw;
				surface_quality <= pend.surface_quality;
				shutter_value <= pend.shutter_value;
				pixel_max <= pend.pixel_max;
				pixel_min <= pend.pixel_min;
				in_valid <= 1'b1;
				wait_left = draw_idle();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (poll_verdict_q.size() == 0) begin
					log_mismatch("beat with nothing expected", 0, 0);
				end else begin
					want = poll_verdict_q.pop_front();
					if (key_direction !== want.key_direction)
						log_mismatch("key_direction", int'(key_direction),
							int'(want.key_direction));
					if (clear_motion !== want.clear_motion)
						log_mismatch("clear_motion", int'(clear_motion),
							int'(want.clear_motion));
					if (reenable_interrupt !== want.reenable_interrupt)
						log_mismatch("reenable_interrupt", int'(reenable_interrupt),
							int'(want.reenable_interrupt));
					if (quality_reject !== want.quality_reject)
						log_mismatch("quality_reject", int'(quality_reject),
							int'(want.quality_reject));
				end
				beat_cnt++;
				stall_left = draw_idle();
			end
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// APB write with random bits above the field width
	task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned value,
			input int width);
		logic [31:0] mask;
		logic [31:0] word;
		mask = (width >= 32) ? 32'hFFFF_FFFF : ((32'h1 << width) - 32'h1);
		word = ($urandom() & ~mask) | (value & mask);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_STEP_MARGIN:      reg_shadow.step_margin = word[7:0];
			REG_TILT_RATIO:       reg_shadow.tilt_ratio = word[7:0];
			REG_SHUTTER_MIN:      reg_shadow.shutter_min = word[15:0];
			REG_PIXEL_SPREAD_MAX: reg_shadow.pixel_spread_max = word[7:0];
			REG_QUALITY_MIN:      reg_shadow.quality_min = word[7:0];
			REG_DIST_RESET_LIMIT: reg_shadow.disturbance_reset_limit = word[15:0];
			REG_KEY_DIST_LIMIT:   reg_shadow.key_disturbance_limit = word[15:0];
			default: ;
		endcase
	endtask

	task automatic load_config(input int ms, input int tr, input int sm, input int sp,
			input int qm, input int rl, input int kl);
		write_reg(REG_STEP_MARGIN, ms, 8);
		write_reg(REG_TILT_RATIO, tr, 8);
		write_reg(REG_SHUTTER_MIN, sm, 16);
		write_reg(REG_PIXEL_SPREAD_MAX, sp, 8);
		write_reg(REG_QUALITY_MIN, qm, 8);
		write_reg(REG_DIST_RESET_LIMIT, rl, 16);
		write_reg(REG_KEY_DIST_LIMIT, kl, 16);
	endtask

	// wait until every poll is through, then let the pipeline drain
	task automatic settle();
		while (poll_q.size() != 0 || in_valid || poll_verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic item_t mk(int ovf, int mf, int pin, logic [7:0] dx, logic [7:0] dy,
			logic [7:0] sq, logic [15:0] sh, logic [7:0] pmax, logic [7:0] pmin);
		item_t p;
		p.overflow_flag = 1'(ovf);
		p.motion_flag = 1'(mf);
		p.motion_pin = 1'(pin);
		p.delta_x_raw = dx;
		p.delta_y_raw = dy;
		p.surface_quality = sq;
		p.shutter_value = sh;
		p.pixel_max = pmax;
		p.pixel_min = pmin;
		return p;
	endfunction

	// random delta with magnitude in [lo, hi], random sign
	function automatic logic [7:0] signed_byte(int lo, int hi);
		int m;
		if (hi > 127)
			hi = 127;
		if (lo > hi)
			lo = hi;
		m = $urandom_range(lo, hi);
		return ($urandom_range(0, 1) != 0) ? 8'(-m) : 8'(m);
	endfunction

	function automatic logic [7:0] zero_y();
		return ($urandom_range(0, 1) != 0) ? DY_NULL_CODE : 8'h00;
	endfunction

	function automatic item_t rand_poll();
		item_t p;
		int d, ms, big;
		logic [7:0] tmp;
		p.overflow_flag = 1'($urandom_range(0, 1));
		p.motion_flag = 1'($urandom_range(0, 1));
		p.motion_pin = 1'($urandom_range(0, 1));
		p.delta_x_raw = 8'($urandom);
		p.delta_y_raw = 8'($urandom);
		p.surface_quality = 8'($urandom);
		p.shutter_value = 16'($urandom);
		p.pixel_max = 8'($urandom);
		p.pixel_min = 8'($urandom);
		// a quarter of the polls are plain noise
		if ($urandom_range(0, 3) == 0)
			return p;
		p.overflow_flag = 1'b0;
		p.motion_flag = 1'b1;
		p.motion_pin = 1'b1;
		if ($urandom_range(0, 99) < 65) begin
			// image passes all quality checks
			if (reg_shadow.quality_min == 8'hFF)
				p.surface_quality = 8'hFF;
			else
				p.surface_quality =
					8'($urandom_range(int'(reg_shadow.quality_min) + 1, 255));
			p.shutter_value = 16'($urandom_range(int'(reg_shadow.shutter_min), 65535));
			d = $urandom_range(0, int'(reg_shadow.pixel_spread_max));
			p.pixel_min = 8'($urandom_range(0, 255 - d));
			p.pixel_max = p.pixel_min + 8'(d);
		end else begin
			// force one quality failure where the settings allow it
			case ($urandom_range(0, 2))
				0: p.surface_quality = 8'($urandom_range(0, int'(reg_shadow.quality_min)));
				1: begin
					if (reg_shadow.shutter_min != 0)
						p.shutter_value =
							16'($urandom_range(0, int'(reg_shadow.shutter_min) - 1));
				end
				default: begin
					if (reg_shadow.pixel_spread_max != 8'hFF) begin
						d = $urandom_range(int'(reg_shadow.pixel_spread_max) + 1, 255);
						p.pixel_min = 8'($urandom_range(0, 255 - d));
						p.pixel_max = p.pixel_min + 8'(d);
					end
				end
			endcase
		end
		if ($urandom_range(0, 1) != 0) begin
			tmp = p.pixel_max;
			p.pixel_max = p.pixel_min;
			p.pixel_min = tmp;
		end
		ms = int'(reg_shadow.step_margin);
		case ($urandom_range(0, 9))
			0: begin
				p.delta_x_raw = 8'h00;
				p.delta_y_raw = zero_y();
			end
			1, 2: begin
				// movement on one axis only, within the margin when it is nonzero
				if ($urandom_range(0, 1) != 0) begin
					p.delta_x_raw = signed_byte(1, (ms < 1) ? 1 : ms);
					p.delta_y_raw = zero_y();
				end else begin
					p.delta_x_raw = 8'h00;
					p.delta_y_raw = signed_byte(1, (ms < 1) ? 1 : ms);
				end
			end
			3, 4, 5: begin
				// one axis clearly larger, minor axis anywhere up to it
				big = $urandom_range(ms + 1 > 127 ? 127 : ms + 1, 127);
				tmp = signed_byte(0, big);
				if ($urandom_range(0, 1) != 0) begin
					p.delta_x_raw = signed_byte(big, big);
					p.delta_y_raw = (tmp == 8'h00) ? zero_y() : tmp;
				end else begin
					p.delta_y_raw = signed_byte(big, big);
					p.delta_x_raw = tmp;
				end
			end
			6: begin
				p.delta_x_raw = signed_byte(1, (ms < 1) ? 1 : ms);
				p.delta_y_raw = signed_byte(1, (ms < 1) ? 1 : ms);
			end
			default: ;
		endcase
		return p;
	endfunction

	task automatic run_phase(input int n_polls, input bit idling);
		idle_on = idling;
		repeat (n_polls)
			poll_q.push_back(rand_poll());
		settle();
	endtask

	initial begin
		reg_shadow.step_margin = RST_STEP_MARGIN;
		reg_shadow.tilt_ratio = RST_TILT_RATIO;
		reg_shadow.shutter_min = RST_SHUTTER_MIN;
		reg_shadow.pixel_spread_max = RST_PIXEL_SPREAD_MAX;
		reg_shadow.quality_min = RST_QUALITY_MIN;
		reg_shadow.disturbance_reset_limit = RST_DIST_RESET_LIMIT;
		reg_shadow.key_disturbance_limit = RST_KEY_DIST_LIMIT;
		dist_cnt = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed polls against the reset settings
		idle_on = 1'b1;
		poll_q.push_back(mk(1, 1, 1, 8'h7F, 8'h80, 8'h00, 16'h0000, 8'hFF, 8'h00));
		poll_q.push_back(mk(0, 0, 1, 8'h40, 8'h40, 8'hFF, 16'hFFFF, 8'h10, 8'h10));
		poll_q.push_back(mk(0, 1, 0, 8'h40, 8'h00, 8'h64, 16'd1000, 8'd150, 8'd50));
		// quality failures: shutter, spread, quality at threshold
		poll_q.push_back(mk(0, 1, 1, 8'h40, 8'h00, 8'h64, 16'd89, 8'd150, 8'd50));
		poll_q.push_back(mk(0, 1, 1, 8'h40, 8'h00, 8'h64, 16'd1000, 8'd255, 8'd0));
		poll_q.push_back(mk(0, 1, 1, 8'h40, 8'h00, 8'd12, 16'd1000, 8'd150, 8'd50));
		// good image right at every threshold, no motion
		poll_q.push_back(mk(0, 1, 1, 8'h00, 8'h00, 8'd13, 16'd90, 8'd0, 8'd226));
		poll_q.push_back(mk(0, 1, 1, 8'h00, 8'h80, 8'd13, 16'd90, 8'd226, 8'd0));
		// moves within margin: single axis, then both axes
		poll_q.push_back(mk(0, 1, 1, 8'h02, 8'h80, 8'h64, 16'd1000, 8'd150, 8'd50));
		poll_q.push_back(mk(0, 1, 1, 8'h00, 8'hFE, 8'h64, 16'd1000, 8'd150, 8'd50));
		poll_q.push_back(mk(0, 1, 1, 8'h01, 8'hFF, 8'h64, 16'd1000, 8'd150, 8'd50));
		// extremes of each direction
		poll_q.push_back(mk(0, 1, 1, 8'h7F, 8'h00, 8'h64, 16'd1000, 8'd150, 8'd50));
		poll_q.push_back(mk(0, 1, 1, 8'h80, 8'h00, 8'h64, 16'd1000, 8'd150, 8'd50));
		poll_q.push_back(mk(0, 1, 1, 8'h00, 8'h7F, 8'h64, 16'd1000, 8'd150, 8'd50));
		poll_q.push_back(mk(0, 1, 1, 8'h00, 8'h81, 8'h64, 16'd1000, 8'd150, 8'd50));
		// margin and tilt boundaries
		poll_q.push_back(mk(0, 1, 1, 8'd10, 8'd7, 8'h64, 16'd1000, 8'd150, 8'd50));
		poll_q.push_back(mk(0, 1, 1, 8'd10, 8'd8, 8'h64, 16'd1000, 8'd150, 8'd50));
		poll_q.push_back(mk(0, 1, 1, 8'd20, 8'd16, 8'h64, 16'd1000, 8'd150, 8'd50));
		poll_q.push_back(mk(0, 1, 1, 8'd3, 8'h80, 8'h64, 16'd1000, 8'd150, 8'd50));
		// key held back once disturbance reaches the limit
		repeat (4)
			poll_q.push_back(mk(0, 1, 1, 8'h00, 8'h00, 8'd0, 16'd1000, 8'd150, 8'd50));
		poll_q.push_back(mk(0, 1, 1, 8'hC0, 8'h01, 8'h64, 16'd1000, 8'd150, 8'd50));
		settle();

		run_phase(300, 1'b1);
		// low extremes, every reject clears, keys always pass
		load_config(0, 0, 0, 255, 0, 0, 65535);
		run_phase(200, 1'b0);
		// high extremes, keys never pass
		load_config(255, 255, 65535, 0, 254, 65534, 0);
		run_phase(150, 1'b1);
		// random settings with small limits so the counter wraps often
		repeat (4) begin
			load_config($urandom_range(0, 20), $urandom_range(0, 40), $urandom_range(0, 200),
				$urandom_range(150, 255), $urandom_range(0, 40), $urandom_range(0, 10),
				$urandom_range(0, 6));
			run_phase(160, 1'($urandom_range(0, 1)));
		end

		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/fmkc_pkg.sv
hw/rtl/fmkc_regs.sv
hw/rtl/fmkc_classify.sv
hw/rtl/finger_motion_key_classifier_core.sv
sim/tb.sv
